// File: hdl/aedp_pkg.sv
// Package for the alpha edge dilation pass: widths, register indexes and
// the item, command and configuration types that the block's modules share.
// No dependencies.
package aedp_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int IDX_W     = $clog2(MAX_WIDTH);
   localparam int COL_W     = IDX_W + 1;

   localparam logic [7:0] CSR_FRAME_WIDTH     = 8'd0;
   localparam logic [7:0] CSR_FRAME_HEIGHT    = 8'd1;
   localparam logic [7:0] CSR_ALPHA_THRESHOLD = 8'd2;
   localparam logic [7:0] CSR_BYTES_PER_PIXEL = 8'd3;

   localparam logic [7:0] KEY_OPAQUE = 8'd255;

   typedef struct packed {
      logic       command;
      logic [7:0] chan_zero;
      logic [7:0] chan_one;
      logic [7:0] chan_two;
      logic [7:0] chan_three;
   } req_type;

   typedef struct packed {
      logic [7:0] out_zero;
      logic [7:0] out_one;
      logic [7:0] out_two;
      logic [7:0] out_three;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic             store_only;
      logic             emit;
      logic [31:0]      pix;
      logic [IDX_W-1:0] col;
      logic             up_en;
      logic             left_en;
      logic             right_en;
      logic             down_en;
      logic             frame_end;
   } cmd_type;

   typedef struct packed {
      logic [7:0] threshold;
      logic       three;
   } cfg_type;

endpackage

// File: hdl/aedp_queue.sv
// Two-entry command queue between the front and back of the dilation pass.
// Depends on aedp_pkg.
module aedp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  aedp_pkg::cmd_type din,
   output logic             full,
   input  logic             pop,
   output aedp_pkg::cmd_type dout,
   output logic             empty
);

   aedp_pkg::cmd_type entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign dout    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= din;
      end
   end

endmodule

// File: hdl/aedp_front.sv
// Front of the dilation pass: configuration registers, raster counters and
// classification of each item into a command for the back. Depends on aedp_pkg.
module aedp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_data,
   input  logic              item_valid,
   input  aedp_pkg::req_type item,
   output logic              cmd_push,
   output aedp_pkg::cmd_type cmd,
   output aedp_pkg::cfg_type cfg
);

   localparam int COL_W = aedp_pkg::COL_W;
   localparam int IDX_W = aedp_pkg::IDX_W;

   logic [11:0]      fw_ff;
   logic [15:0]      fh_ff;
   logic [7:0]       thr_ff;
   logic [2:0]       bpp_ff;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [15:0]      in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [15:0]      out_row_ff, out_row_in;

   logic [COL_W-1:0] w;
   logic [15:0]      h;
   logic             three;
   logic [COL_W-1:0] c;
   logic [COL_W-1:0] c_next;
   logic [15:0]      orow;
   logic             restart;

   assign three = (bpp_ff == 3'd3);
   assign cfg   = '{threshold: thr_ff, three: three};
   assign restart = csr_valid && ((csr_index == aedp_pkg::CSR_FRAME_WIDTH) ||
                                  (csr_index == aedp_pkg::CSR_FRAME_HEIGHT) ||
                                  (csr_index == aedp_pkg::CSR_BYTES_PER_PIXEL));

   always_comb begin
      priority if (fw_ff == 12'd0) begin
         w = COL_W'(1);
      end else if (32'(fw_ff) > aedp_pkg::MAX_WIDTH) begin
         w = COL_W'(aedp_pkg::MAX_WIDTH);
      end else begin
         w = COL_W'(fw_ff);
      end
      h = (fh_ff == 16'd0) ? 16'd1 : fh_ff;
   end

   always_comb begin
      cmd_push   = 1'b0;
      cmd        = '0;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      c          = '0;
      orow       = out_row_ff;
      if (item.command) begin
         c = (out_col_ff < w) ? out_col_ff : w - COL_W'(1);
      end else begin
         c = (in_col_ff < w) ? in_col_ff : w - COL_W'(1);
         orow = in_row_ff - 16'd1;
      end
      c_next = c + COL_W'(1);

      cmd.pix = {three ? 8'd0 : item.chan_three, item.chan_two, item.chan_one,
                 item.chan_zero};
      cmd.col       = c[IDX_W-1:0];
      cmd.up_en     = (orow != 16'd0);
      cmd.left_en   = (c != '0);
      cmd.right_en  = (c_next < w);
      cmd.frame_end = (orow == h - 16'd1) && (c == w - COL_W'(1));

      if (item_valid) begin
         if (item.command) begin
            if (in_row_ff >= h) begin
               cmd_push    = 1'b1;
               cmd.emit    = 1'b1;
               cmd.down_en = 1'b0;
               out_col_in  = c_next;
               if (c_next >= w) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 16'd1;
               end
               if (out_row_in >= h) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
                  out_row_in = '0;
               end
            end
         end else if (in_row_ff < h) begin
            cmd_push = 1'b1;
            if (in_row_ff == 16'd0) begin
               cmd.store_only = 1'b1;
            end else begin
               cmd.emit    = 1'b1;
               cmd.down_en = 1'b1;
               out_row_in  = orow;
               out_col_in  = c_next;
               if (c_next >= w) begin
                  out_col_in = '0;
                  out_row_in = in_row_ff;
               end
            end
            in_col_in = c_next;
            if (c_next >= w) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= 12'd64;
         fh_ff      <= 16'd64;
         thr_ff     <= 8'd10;
         bpp_ff     <= 3'd4;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               aedp_pkg::CSR_FRAME_WIDTH:     fw_ff  <= csr_data[11:0];
               aedp_pkg::CSR_FRAME_HEIGHT:    fh_ff  <= csr_data;
               aedp_pkg::CSR_ALPHA_THRESHOLD: thr_ff <= csr_data[7:0];
               aedp_pkg::CSR_BYTES_PER_PIXEL: bpp_ff <= csr_data[2:0];
               default: ;
            endcase
         end
         if (restart) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
      end
   end

endmodule

// File: hdl/aedp_back.sv
// Back of the dilation pass: line stores, neighbour selection and the
// two-entry result queue. Depends on aedp_pkg.
module aedp_back (
   input  logic              clock,
   input  logic              reset,
   input  aedp_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  aedp_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output aedp_pkg::rsp_type rsp_data
);

   localparam int IDX_W = aedp_pkg::IDX_W;

   logic [31:0] curr_mem [aedp_pkg::MAX_WIDTH];
   logic [31:0] prev_mem [aedp_pkg::MAX_WIDTH];

   aedp_pkg::cmd_type s2_ff;
   logic              s2_valid_ff;
   logic [31:0]       centre_ff, right_ff, up_ff, left_ff;

   aedp_pkg::rsp_type out_ff [2];
   logic       owp_ff, orp_ff;
   logic [1:0] ocnt_ff, ocnt_in;

   logic             s2_fire, load;
   logic             curr_we, prev_we;
   logic [IDX_W-1:0] ra_a, ra_b, wa;
   logic [31:0]      curr_wd;
   logic [31:0]      res, cand;
   logic             hit;
   logic             out_push, out_pop;
   aedp_pkg::rsp_type rsp;

   function automatic logic opaque(input logic [31:0] p, input aedp_pkg::cfg_type k);
      logic [7:0] key;
      key = k.three ? p[23:16] : p[31:24];
      return key > k.threshold;
   endfunction

   assign s2_fire = s2_valid_ff && (!s2_ff.emit || (ocnt_ff != 2'd2));
   assign load    = !q_empty && (!s2_valid_ff || s2_fire);
   assign q_pop   = load;
   assign ra_a    = q_head.col;
   assign ra_b    = q_head.col + IDX_W'(1);
   assign wa      = s2_ff.col;
   assign curr_we = s2_fire && (s2_ff.store_only || s2_ff.down_en);
   assign prev_we = s2_fire && s2_ff.emit;
   assign curr_wd = s2_ff.pix;

   always_ff @(posedge clock) begin
      if (curr_we) begin
         curr_mem[wa] <= curr_wd;
      end
      if (prev_we) begin
         prev_mem[wa] <= centre_ff;
      end
      if (load) begin
         centre_ff <= (curr_we && wa == ra_a) ? curr_wd : curr_mem[ra_a];
         right_ff  <= (curr_we && wa == ra_b) ? curr_wd : curr_mem[ra_b];
         up_ff     <= (prev_we && wa == ra_a) ? centre_ff : prev_mem[ra_a];
         s2_ff     <= q_head;
      end
      if (prev_we) begin
         left_ff <= centre_ff;
      end
   end

   always_comb begin
      hit  = 1'b1;
      cand = centre_ff;
      priority if (s2_ff.up_en && opaque(up_ff, cfg)) begin
         cand = up_ff;
      end else if (s2_ff.left_en && opaque(left_ff, cfg)) begin
         cand = left_ff;
      end else if (s2_ff.right_en && opaque(right_ff, cfg)) begin
         cand = right_ff;
      end else if (s2_ff.down_en && opaque(s2_ff.pix, cfg)) begin
         cand = s2_ff.pix;
      end else begin
         hit = 1'b0;
      end
      if (!opaque(centre_ff, cfg) && hit) begin
         res = cfg.three ? {8'd0, aedp_pkg::KEY_OPAQUE, cand[15:0]}
                         : {aedp_pkg::KEY_OPAQUE, cand[23:0]};
      end else begin
         res = cfg.three ? {8'd0, centre_ff[23:0]} : centre_ff;
      end
      rsp = '{out_zero: res[7:0], out_one: res[15:8], out_two: res[23:16],
              out_three: res[31:24], frame_end: s2_ff.frame_end};
   end

   assign out_push  = s2_fire && s2_ff.emit;
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_data  = out_ff[orp_ff];
   assign ocnt_in   = ocnt_ff + 2'(out_push) - 2'(out_pop);

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[owp_ff] <= rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         owp_ff      <= 1'b0;
         orp_ff      <= 1'b0;
         ocnt_ff     <= 2'd0;
      end else begin
         if (load) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_fire) begin
            s2_valid_ff <= 1'b0;
         end
         owp_ff  <= out_push ? !owp_ff : owp_ff;
         orp_ff  <= out_pop ? !orp_ff : orp_ff;
         ocnt_ff <= ocnt_in;
      end
   end

endmodule

// File: hdl/alpha_edge_dilate_pass_unit.sv
// Top level of the alpha edge dilation pass: front, command queue and back.
// Depends on aedp_pkg, aedp_front, aedp_queue and aedp_back.
//
// One item is taken per clock cycle while req_full is low. Each pixel of a
// row is answered by the pixel one row below it, so results trail input by
// one row; drain items deliver the last row, one pixel each. Results are
// registered: the front classifies, the back reads the two line stores and
// picks the first opaque neighbour (up, left, right, down). Each line
// store has a single write port; the back takes one item per cycle unless the
// result queue is full. Configuration writes are taken at any cycle.
module alpha_edge_dilate_pass_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  aedp_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output aedp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_data
);

   aedp_pkg::cmd_type cmd, q_head;
   aedp_pkg::cfg_type cfg;
   logic cmd_push, q_empty, q_pop;

   assign csr_ready = 1'b1;

   aedp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (req_push && !req_full),
      .item       (req_data),
      .cmd_push   (cmd_push),
      .cmd        (cmd),
      .cfg        (cfg)
   );

   aedp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd),
      .full  (req_full),
      .pop   (q_pop),
      .dout  (q_head),
      .empty (q_empty)
   );

   aedp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/aedp_checker.sv
// Port checker for the alpha edge dilation pass, bound to the top level.
// Depends on aedp_pkg and alpha_edge_dilate_pass_unit.
module aedp_port_props (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input aedp_pkg::rsp_type rsp_data
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_open_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting item lost");

   a_result_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting item changed");

endmodule

bind alpha_edge_dilate_pass_unit aedp_port_props u_aedp_port_props (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// File: verif/aedp_checker.sv
// Checker for the alpha edge dilation pass: watches the item, result and
// register channels, predicts each result and compares it as a whole.
// Depends on aedp_pkg.
`timescale 1ns / 1ps

module aedp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  aedp_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  aedp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_data,
   output int                fail_count,
   output int                pending
);

   logic [11:0] frame_width;
   logic [15:0] frame_height;
   logic [7:0]  alpha_threshold;
   logic [2:0]  bytes_per_pixel;

   logic [31:0] prev_row [aedp_pkg::MAX_WIDTH];
   logic [31:0] cur_row [aedp_pkg::MAX_WIDTH];
   logic [31:0] left_pix;
   int unsigned in_col, in_row, out_col, out_row;

   aedp_pkg::rsp_type dilated_q[$];

   assign pending = dilated_q.size();

   function automatic int unsigned width_eff();
      if (frame_width == 0) return 1;
      if (frame_width > aedp_pkg::MAX_WIDTH) return aedp_pkg::MAX_WIDTH;
      return frame_width;
   endfunction

   function automatic int unsigned height_eff();
      return (frame_height == 0) ? 1 : frame_height;
   endfunction

   function automatic logic is_three();
      return bytes_per_pixel == 3'd3;
   endfunction

   function automatic logic is_opaque(logic [31:0] p);
      logic [7:0] key;
      key = is_three() ? p[23:16] : p[31:24];
      return key > alpha_threshold;
   endfunction

   task automatic restart_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      left_pix = '0;
   endtask

   task automatic dilate_pixel(input logic [31:0] down, input logic [31:0] incoming,
                               input logic store_in);
      int unsigned w, h, c;
      logic [31:0] centre, res;
      logic [31:0] cand [4];
      aedp_pkg::rsp_type r;
      w = width_eff();
      h = height_eff();
      c = (out_col < w) ? out_col : w - 1;
      centre = cur_row[c];
      res = centre;
      cand[0] = (out_row == 0) ? centre : prev_row[c];
      cand[1] = (c == 0) ? centre : left_pix;
      cand[2] = (c + 1 >= w) ? centre : cur_row[c + 1];
      cand[3] = down;
      if (!is_opaque(centre)) begin
         for (int i = 0; i < 4; i++) begin
            if (is_opaque(cand[i])) begin
               if (is_three()) res = {8'd0, aedp_pkg::KEY_OPAQUE, cand[i][15:0]};
               else res = {aedp_pkg::KEY_OPAQUE, cand[i][23:0]};
               break;
            end
         end
      end
      if (is_three()) res[31:24] = 8'd0;
      r.out_zero  = res[7:0];
      r.out_one   = res[15:8];
      r.out_two   = res[23:16];
      r.out_three = res[31:24];
      r.frame_end = (out_row == h - 1) && (c == w - 1);
      dilated_q.push_back(r);
      left_pix = centre;
      prev_row[c] = centre;
      if (store_in) cur_row[c] = incoming;
      out_col = c + 1;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
   endtask

   task automatic take_item(input aedp_pkg::req_type it);
      int unsigned w, h, c;
      logic [31:0] pix;
      w = width_eff();
      h = height_eff();
      if (it.command) begin
         if (in_row >= h) begin
            dilate_pixel('0, '0, 1'b0);
            if (out_row >= h) restart_frame();
         end
      end else if (in_row < h) begin
         pix = {is_three() ? 8'd0 : it.chan_three, it.chan_two, it.chan_one, it.chan_zero};
         c = (in_col < w) ? in_col : w - 1;
         if (in_row == 0) begin
            cur_row[c] = pix;
         end else begin
            out_row = in_row - 1;
            out_col = c;
            dilate_pixel(pix, pix, 1'b1);
         end
         in_col = c + 1;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      case (idx)
         aedp_pkg::CSR_FRAME_WIDTH: begin
            frame_width = val[11:0];
            restart_frame();
         end
         aedp_pkg::CSR_FRAME_HEIGHT: begin
            frame_height = val;
            restart_frame();
         end
         aedp_pkg::CSR_ALPHA_THRESHOLD: alpha_threshold = val[7:0];
         aedp_pkg::CSR_BYTES_PER_PIXEL: begin
            bytes_per_pixel = val[2:0];
            restart_frame();
         end
         default: ;
      endcase
   endtask

   task automatic check_result(input aedp_pkg::rsp_type got);
      aedp_pkg::rsp_type want;
      if (dilated_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("unexpected result %h", got);
         return;
      end
      want = dilated_q.pop_front();
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("result mismatch: expected %h %h %h %h end %b, got %h %h %h %h end %b",
                     want.out_zero, want.out_one, want.out_two, want.out_three,
                     want.frame_end, got.out_zero, got.out_one, got.out_two,
                     got.out_three, got.frame_end);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_width = 12'd64;
         frame_height = 16'd64;
         alpha_threshold = 8'd10;
         bytes_per_pixel = 3'd4;
         restart_frame();
         dilated_q.delete();
         fail_count = 0;
      end else begin
         if (!rsp_empty && rsp_pop) check_result(rsp_data);
         if (csr_valid && csr_ready) write_reg(csr_index, csr_data);
         if (req_push && !req_full) take_item(req_data);
      end
   end

endmodule

// File: verif/tb_top.sv
// Top of the alpha edge dilation pass testbench: clock, reset, frame
// stimulus, register writes and the verdict.
// Depends on aedp_pkg, alpha_edge_dilate_pass_unit and aedp_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [7:0] CSR_UNUSED = 8'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_GOAL = 1050;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   aedp_pkg::req_type req_data;
   logic              rsp_empty;
   logic              rsp_pop;
   aedp_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_index;
   logic [15:0]       csr_data;
   int                fail_count;
   int                pending;
   int                cycles;
   int                items_sent;
   logic [7:0]        cur_thr;
   logic              cur_three;

   alpha_edge_dilate_pass_unit u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   aedp_checker u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic quiet();
      return items_sent >= 300 && items_sent < 520;
   endfunction

   function automatic logic go_idle();
      return !quiet() && $urandom_range(99) < 29;
   endfunction

   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !go_idle();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL alpha_edge_dilate_pass_unit");
         $finish;
      end
   end

   task automatic send(input aedp_pkg::req_type it);
      @(negedge clock);
      while (go_idle()) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic send_pixel(input logic [31:0] p);
      aedp_pkg::req_type it;
      it = {1'b0, p[7:0], p[15:8], p[23:16], p[31:24]};
      send(it);
   endtask

   task automatic send_drain();
      aedp_pkg::req_type it;
      it = {1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      send(it);
   endtask

   function automatic logic [31:0] rand_pixel();
      logic [31:0] p;
      logic [7:0] key;
      p = $urandom;
      case ($urandom_range(3))
         0: key = cur_thr;
         1: key = cur_thr + 8'd1;
         default: key = 8'($urandom);
      endcase
      if (cur_three) p[23:16] = key;
      else p[31:24] = key;
      return p;
   endfunction

   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      wait (pending == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(input logic [15:0] w, input logic [15:0] h,
                               input logic [7:0] thr, input logic [2:0] bpp);
      settle();
      csr_write(aedp_pkg::CSR_FRAME_WIDTH, w);
      csr_write(aedp_pkg::CSR_FRAME_HEIGHT, h);
      csr_write(aedp_pkg::CSR_ALPHA_THRESHOLD, {8'($urandom), thr});
      csr_write(aedp_pkg::CSR_BYTES_PER_PIXEL, {13'($urandom), bpp});
      cur_thr = thr;
      cur_three = (bpp == 3'd3);
   endtask

   task automatic run_frame(input int w, input int h, input int noise_pct);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(99) < noise_pct) send_drain();
         send_pixel(rand_pixel());
      end
      for (int i = 0; i < w; i++) begin
         if ($urandom_range(99) < noise_pct) send_pixel(rand_pixel());
         send_drain();
      end
   endtask

   initial begin
      int we, he;
      logic [2:0] bpp;
      logic [7:0] thr;
      logic [11:0] wreg;
      logic [15:0] hreg;
      logic paused;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      items_sent = 0;
      paused = 1'b0;
      cur_thr = 8'd10;
      cur_three = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(CSR_UNUSED, 16'hffff);
      set_geometry(16'd3, 16'd2, 8'd10, 3'd4);
      send_drain();
      send_pixel(32'h00_000000);
      send_pixel(32'h0b_ffffff);
      send_pixel(32'h0a_123456);
      send_pixel(32'hff_00ff00);
      send_pixel(32'h00_abcdef);
      send_pixel(32'h0a_ffffff);
      send_pixel(32'hff_ffffff);
      send_drain();
      send_drain();
      send_drain();
      set_geometry(16'd1, 16'd0, 8'd0, 3'd3);
      send_pixel(32'hff_01ff02);
      send_drain();
      set_geometry(16'd2, 16'd2, 8'd255, 3'd0);
      run_frame(2, 2, 0);

      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(9))
            0: wreg = 12'd0;
            1: wreg = 12'd1;
            2: wreg = 12'd2;
            default: wreg = 12'($urandom_range(16, 1));
         endcase
         case ($urandom_range(7))
            0: hreg = 16'd0;
            1: hreg = 16'd1;
            default: hreg = 16'($urandom_range(6, 2));
         endcase
         case ($urandom_range(5))
            0: thr = 8'd0;
            1: thr = 8'd255;
            default: thr = 8'($urandom);
         endcase
         case ($urandom_range(5))
            0: bpp = 3'($urandom);
            1, 2: bpp = 3'd3;
            default: bpp = 3'd4;
         endcase
         set_geometry(16'(wreg), hreg, thr, bpp);
         we = (wreg == 0) ? 1 : wreg;
         he = (hreg == 0) ? 1 : hreg;
         for (int f = $urandom_range(3, 1); f > 0 && items_sent < ITEM_GOAL; f--) begin
            run_frame(we, he, $urandom_range(99) < 70 ? 0 : 6);
            if (!paused && items_sent > 600) begin
               paused = 1'b1;
               @(negedge clock);
               req_push <= 1'b0;
               wait (pending == 0);
            end
         end
      end

      set_geometry(16'd4095, 16'd1, 8'd128, 3'd4);
      for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
      set_geometry(16'd5, 16'd65535, 8'd20, 3'd3);
      for (int i = 0; i < 15; i++) send_pixel(rand_pixel());
      set_geometry(16'd2048, 16'd2, 8'd10, 3'd4);
      run_frame(2, 1, 0);

      @(negedge clock);
      req_push <= 1'b0;
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("PASS alpha_edge_dilate_pass_unit");
      else $display("FAIL alpha_edge_dilate_pass_unit");
      $finish;
   end

endmodule
